[hw/rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types, codes and fixed-point helpers of the cascaded position/rate
// controller.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_POS_GAIN    = 3'd0;
  localparam logic [2:0] REG_RATE_P_GAIN = 3'd1;
  localparam logic [2:0] REG_RATE_I_GAIN = 3'd2;
  localparam logic [2:0] REG_RATE_D_GAIN = 3'd3;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [2:0] REG_FILTER      = 3'd6;

  localparam logic [14:0] LIMIT_RESET = 15'd127;

  // wide working word
  localparam int unsigned WW  = 65;
  // divider dividend width
  localparam int unsigned DVW = 58;

  // datapath micro operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MRT, OP_ERR, OP_MP, OP_PT, OP_MI, OP_T, OP_MTD,
    OP_INT, OP_DIFF, OP_DS1, OP_RAW, OP_MF, OP_DS2, OP_DERIV, OP_MD, OP_DT,
    OP_SUM, OP_CLR
  } op_t;

  typedef struct packed {
    op_t op;
  } cpr_cmd_t;

  typedef struct packed {
    logic i_en;
    logic d_en;
    logic div_done;
  } cpr_sts_t;

  // divide by 2**k, truncated toward zero
  function automatic logic signed [WW-1:0] tdiv_pow2(logic signed [WW-1:0] x,
                                                     int unsigned k);
    logic signed [WW-1:0] bias;
    bias = x[WW-1] ? ((WW'(1) <<< k) - WW'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  // saturate to the signed 40-bit range
  function automatic logic signed [39:0] sat40(logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = WW'(40'sh7F_FFFF_FFFF);
    lo = -hi - WW'(1);
    if (x > hi) return 40'sh7F_FFFF_FFFF;
    if (x < lo) return 40'sh80_0000_0000;
    return x[39:0];
  endfunction

  // symmetric clamp
  function automatic logic signed [WW-1:0] clampsym(logic signed [WW-1:0] x,
                                                    logic signed [WW-1:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

endpackage

[hw/rtl/cpr_if.sv]
// ----------------------------------------------------------------------------
// cpr_in_if / cpr_out_if
// Valid/ready channels carrying input words and drive words.
// ----------------------------------------------------------------------------
interface cpr_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] target;
  logic signed [15:0] position;
  logic signed [15:0] speed;
  logic        [15:0] dt;
  modport source (output valid, action, target, position, speed, dt, input ready);
  modport sink   (input valid, action, target, position, speed, dt, output ready);
endinterface

interface cpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

[hw/rtl/cpr_div.sv]
// ----------------------------------------------------------------------------
// cpr_div
// Sequential signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cpr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [cpr_pkg::DVW-1:0] dividend,
  input  logic        [16:0]            divisor,
  output logic signed [cpr_pkg::DVW-1:0] quot,
  output logic                          done
);
  import cpr_pkg::*;

  logic [DVW-1:0] mag_r, mag_nxt;
  logic [17:0]    rem_r, rem_nxt;
  logic [16:0]    dvs_r;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           neg_r;
  logic           done_r, done_nxt;
  logic [17:0]    sh;
  logic           qbit;

  // one restoring step
  always_comb begin
    sh      = {rem_r[16:0], mag_r[DVW-1]};
    qbit    = (sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? (sh - {1'b0, dvs_r}) : sh;
    mag_nxt = {mag_r[DVW-2:0], qbit};
    cnt_nxt = cnt_r - 6'd1;
    busy_nxt = (cnt_r != 6'd1);
    done_nxt = (cnt_r == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'(DVW);
      mag_r  <= dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
      neg_r  <= dividend[DVW-1];
      dvs_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      mag_r  <= mag_nxt;
      rem_r  <= rem_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quot = neg_r ? -signed'(mag_r) : signed'(mag_r);
  assign done = done_r;

endmodule

[hw/rtl/cpr_datapath.sv]
// ----------------------------------------------------------------------------
// cpr_datapath
// Configuration registers, controller state, shared multiplier, divider and
// the drive register, stepped by micro operations from the controller.
// ----------------------------------------------------------------------------
module cpr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  target,
  input  logic signed [15:0]  position,
  input  logic signed [15:0]  speed,
  input  logic        [15:0]  dt,
  input  cpr_pkg::cpr_cmd_t   cmd,
  output cpr_pkg::cpr_sts_t   sts,
  output logic signed [15:0]  drive
);
  import cpr_pkg::*;

  // configuration
  logic signed [15:0] pg_r, kp_r, ki_r, kd_r;
  logic        [14:0] olim_r, ilim_r;
  logic        [15:0] filt_r;

  // working registers
  logic signed [16:0]     e0_r;
  logic signed [15:0]     spd_r;
  logic        [15:0]     dt_r;
  logic signed [39:0]     err_r, raw_r;
  logic signed [WW-1:0]   prod_r;
  logic signed [47:0]     pterm_r, t_r, dterm_r;
  logic signed [DVW-1:0]  diff_r;
  logic signed [39:0]     integ_r, prev_err_r, prev_d_r;
  logic signed [15:0]     drive_r;

  logic signed [47:0]     mul_a;
  logic signed [16:0]     mul_b;
  logic signed [WW-1:0]   wide;
  logic signed [WW-1:0]   sum;
  logic signed [WW-1:0]   ilim;
  logic signed [WW-1:0]   dres;
  logic                   div_start;
  logic signed [DVW-1:0]  div_dvd;
  logic        [16:0]     div_dvs;
  logic signed [DVW-1:0]  quot;
  logic                   div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r   <= '0;
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      olim_r <= LIMIT_RESET;
      ilim_r <= LIMIT_RESET;
      filt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_GAIN:    pg_r   <= cfg_data;
        REG_RATE_P_GAIN: kp_r   <= cfg_data;
        REG_RATE_I_GAIN: ki_r   <= cfg_data;
        REG_RATE_D_GAIN: kd_r   <= cfg_data;
        REG_OUT_LIMIT:   olim_r <= cfg_data[14:0];
        REG_INTEG_LIMIT: ilim_r <= cfg_data[14:0];
        REG_FILTER:      filt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_MRT:  begin mul_a = 48'(e0_r);            mul_b = 17'(pg_r); end
      OP_MP:   begin mul_a = 48'(err_r);           mul_b = 17'(kp_r); end
      OP_MI:   begin mul_a = 48'(err_r);           mul_b = 17'(ki_r); end
      OP_MTD:  begin mul_a = t_r;                  mul_b = signed'({1'b0, dt_r}); end
      OP_MF:   begin mul_a = 48'(41'(raw_r) - 41'(prev_d_r));
                     mul_b = signed'({1'b0, dt_r}); end
      OP_MD:   begin mul_a = 48'(prev_d_r);        mul_b = 17'(kd_r); end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  // divider hookup
  assign div_start = (cmd.op == OP_DS1) || (cmd.op == OP_DS2);
  assign div_dvd   = (cmd.op == OP_DS1) ? diff_r : prod_r[DVW-1:0];
  assign div_dvs   = (cmd.op == OP_DS1) ? {1'b0, dt_r} : ({1'b0, filt_r} + {1'b0, dt_r});

  cpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (quot),
    .done     (div_done)
  );

  // shared combinational terms
  always_comb begin
    wide = (prod_r <<< 8) - (WW'(spd_r) <<< 16);
    ilim = WW'({ilim_r, 16'd0});
    sum  = tdiv_pow2(WW'(pterm_r) + WW'(integ_r) + WW'(dterm_r), 16);
    dres = clampsym(sum, WW'({1'b0, olim_r}));
  end

  // micro operations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      prev_d_r   <= '0;
      drive_r    <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          e0_r    <= 17'(target) - 17'(position);
          spd_r   <= speed;
          dt_r    <= dt;
          dterm_r <= '0;
        end
        OP_MRT, OP_MP, OP_MI, OP_MTD, OP_MF, OP_MD: prod_r <= WW'(mul_a) * WW'(mul_b);
        OP_ERR:  err_r   <= sat40(wide);
        OP_PT:   pterm_r <= 48'(tdiv_pow2(prod_r, 8));
        OP_T:    t_r     <= 48'(tdiv_pow2(prod_r, 8));
        OP_INT:  integ_r <= 40'(clampsym(WW'(integ_r) + tdiv_pow2(prod_r, 12), ilim));
        OP_DIFF: diff_r  <= DVW'(41'(err_r) - 41'(prev_err_r)) <<< 12;
        OP_RAW:  raw_r   <= sat40(WW'(quot));
        OP_DERIV: begin
          prev_d_r   <= prev_d_r + 40'(quot);
          prev_err_r <= err_r;
        end
        OP_DT:   dterm_r <= 48'(tdiv_pow2(prod_r, 8));
        OP_SUM:  drive_r <= 16'(dres);
        OP_CLR: begin
          integ_r    <= '0;
          prev_err_r <= '0;
          prev_d_r   <= '0;
          drive_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  assign sts.i_en     = (ki_r != 16'sd0) && (dt_r != 16'd0);
  assign sts.d_en     = (kd_r != 16'sd0) && (dt_r != 16'd0);
  assign sts.div_done = div_done;
  assign drive        = drive_r;

endmodule

[hw/rtl/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl
// Step sequencer: runs the outer loop, P, I and filtered D steps, or a clear,
// and hands the drive word to the result channel.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cpr_pkg::cpr_sts_t sts,
  output cpr_pkg::cpr_cmd_t cmd
);
  import cpr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MRT, ST_ERR, ST_MP, ST_PT, ST_MI, ST_T, ST_MTD, ST_INT,
    ST_DIFF, ST_DS1, ST_DW1, ST_RAW, ST_MF, ST_DS2, ST_DW2, ST_DERIV,
    ST_MD, ST_DT, ST_SUM, ST_CLR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = in_action ? ST_CLR : ST_MRT;
      end
      ST_MRT:  begin cmd.op = OP_MRT; state_nxt = ST_ERR; end
      ST_ERR:  begin cmd.op = OP_ERR; state_nxt = ST_MP; end
      ST_MP:   begin cmd.op = OP_MP;  state_nxt = ST_PT; end
      ST_PT:   begin
        cmd.op    = OP_PT;
        state_nxt = sts.i_en ? ST_MI : (sts.d_en ? ST_DIFF : ST_SUM);
      end
      ST_MI:   begin cmd.op = OP_MI;  state_nxt = ST_T; end
      ST_T:    begin cmd.op = OP_T;   state_nxt = ST_MTD; end
      ST_MTD:  begin cmd.op = OP_MTD; state_nxt = ST_INT; end
      ST_INT:  begin cmd.op = OP_INT; state_nxt = sts.d_en ? ST_DIFF : ST_SUM; end
      ST_DIFF: begin cmd.op = OP_DIFF; state_nxt = ST_DS1; end
      ST_DS1:  begin cmd.op = OP_DS1; state_nxt = ST_DW1; end
      ST_DW1:  if (sts.div_done) state_nxt = ST_RAW;
      ST_RAW:  begin cmd.op = OP_RAW; state_nxt = ST_MF; end
      ST_MF:   begin cmd.op = OP_MF;  state_nxt = ST_DS2; end
      ST_DS2:  begin cmd.op = OP_DS2; state_nxt = ST_DW2; end
      ST_DW2:  if (sts.div_done) state_nxt = ST_DERIV;
      ST_DERIV: begin cmd.op = OP_DERIV; state_nxt = ST_MD; end
      ST_MD:   begin cmd.op = OP_MD;  state_nxt = ST_DT; end
      ST_DT:   begin cmd.op = OP_DT;  state_nxt = ST_SUM; end
      ST_SUM:  if (slot_free) begin
        cmd.op        = OP_SUM;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_CLR:  if (slot_free) begin
        cmd.op        = OP_CLR;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/cascade_position_rate_pid.sv]
// ----------------------------------------------------------------------------
// cascade_position_rate_pid
// Cascaded position/rate controller with clamped integrator and low-pass
// filtered derivative.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per control step: action (0 step, 1 clear),
//   target, position, speed and dt. out_ch returns one drive word per input
//   word, in order. cfg_we/cfg_index/cfg_data write the gains, limits and
//   filter constant; write them only while the block is idle.
//   A step always runs the P path, adds the integrator steps when the I gain
//   and dt are nonzero and the derivative steps when the D gain and dt are
//   nonzero; the derivative holds two sequential divides (each: start, 58
//   quotient bits at one bit per cycle, done). A clear word skips them all.
//   One word is in work at a time; the next word is accepted as soon as the
//   drive word sits in the output register, even while it waits there.
//   If the receiver stalls, the finished drive word holds and the sequencer
//   waits at its last step until the output register is free.
//   Reset (rst_n low at a clock edge) zeroes the state, restores the
//   register defaults and empties the output register.
// ----------------------------------------------------------------------------
module cascade_position_rate_pid (
  input  logic       clk,
  input  logic       rst_n,
  cpr_in_if.sink     in_ch,
  cpr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import cpr_pkg::*;

  cpr_cmd_t cmd;
  cpr_sts_t sts;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .target    (in_ch.target),
    .position  (in_ch.position),
    .speed     (in_ch.speed),
    .dt        (in_ch.dt),
    .cmd       (cmd),
    .sts       (sts),
    .drive     (out_ch.drive)
  );

endmodule
